>>> rtl/core/pts_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and codes of the priority task scheduler.
// ----------------------------------------------------------------------------
package pts_pkg;

  typedef enum logic [2:0] {
    OP_READY    = 3'd0,
    OP_UNREADY  = 3'd1,
    OP_DELAY    = 3'd2,
    OP_WAKE     = 3'd3,
    OP_TICK     = 3'd4,
    OP_LOCK     = 3'd5,
    OP_UNLOCK   = 3'd6,
    OP_SCHEDULE = 3'd7
  } op_t;

  localparam int unsigned LOCK_MAX   = 255;
  localparam int unsigned SLICE_INIT = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK_WALK,
    ST_SLICE,
    ST_SCHED,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

>>> rtl/core/pts_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_front
// Accepts command beats, decodes them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module pts_front
  import pts_pkg::*;
#(
  parameter int NUM_TASKS      = 16,
  parameter int NUM_PRIORITIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  operation,
  input  wire logic [3:0]  task_id,
  input  wire logic [4:0]  priority_req,
  input  wire logic [31:0] delay_ticks,
  input  wire logic        waits_on_event,
  output logic             cmd_valid,
  input  wire logic        cmd_take,
  output op_t              cmd_op,
  output logic             cmd_task_ok,
  output logic [3:0]       cmd_task,
  output logic [4:0]       cmd_prio,
  output logic [31:0]      cmd_ticks,
  output logic             cmd_event
);

  localparam int PW = 5;

  typedef struct packed {
    op_t         op;
    logic        ok;
    logic [3:0]  tsk;
    logic [4:0]  prio;
    logic [31:0] ticks;
    logic        ev;
  } cmd_t;

  cmd_t      slots [2];
  logic      wr_ptr, rd_ptr;
  logic [1:0] fill;
  cmd_t      dec;
  logic      acc;

  always_comb begin
    dec.op    = op_t'(operation);
    dec.ok    = ({28'd0, task_id} < 32'(NUM_TASKS));
    dec.tsk   = task_id;
    dec.prio  = ({27'd0, priority_req} >= 32'(NUM_PRIORITIES)) ?
                PW'(NUM_PRIORITIES - 1) : priority_req;
    dec.ticks = (delay_ticks == 32'd0) ? 32'd1 : delay_ticks;
    dec.ev    = waits_on_event;
  end

  assign full      = fill[1];
  assign acc       = push && !full;
  assign cmd_valid = (fill != 2'd0);
  assign cmd_op       = slots[rd_ptr].op;
  assign cmd_task_ok  = slots[rd_ptr].ok;
  assign cmd_task     = slots[rd_ptr].tsk;
  assign cmd_prio     = slots[rd_ptr].prio;
  assign cmd_ticks    = slots[rd_ptr].ticks;
  assign cmd_event    = slots[rd_ptr].ev;

  always_ff @(posedge clk) begin
    if (acc) begin
      slots[wr_ptr] <= dec;
    end
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (acc) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take && cmd_valid) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, acc} - {1'b0, cmd_take && cmd_valid};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/pts_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_back
// Executes commands on the ready queues; a tick walks tasks one per cycle.
// ----------------------------------------------------------------------------
module pts_back
  import pts_pkg::*;
#(
  parameter int NUM_TASKS      = 16,
  parameter int NUM_PRIORITIES = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  slice_length,
  input  wire logic        cmd_valid,
  output logic             cmd_take,
  input  wire op_t         cmd_op,
  input  wire logic        cmd_task_ok,
  input  wire logic [3:0]  cmd_task,
  input  wire logic [4:0]  cmd_prio,
  input  wire logic [31:0] cmd_ticks,
  input  wire logic        cmd_event,
  output logic             res_valid,
  input  wire logic        res_full,
  output logic             switch_request,
  output logic [3:0]       next_task,
  output logic             any_ready,
  output logic [15:0]      timed_out_mask,
  output logic [7:0]       lock_level
);

  localparam int TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int PW = (NUM_PRIORITIES > 1) ? $clog2(NUM_PRIORITIES) : 1;
  localparam int CW = $clog2(NUM_TASKS + 1);

  logic [NUM_PRIORITIES-1:0] bitmap;
  logic [TW-1:0] qhead  [NUM_PRIORITIES];
  logic [TW-1:0] qtail  [NUM_PRIORITIES];
  logic [CW-1:0] qcount [NUM_PRIORITIES];
  logic [TW-1:0] lnext  [NUM_TASKS];
  logic [TW-1:0] lprev  [NUM_TASKS];
  logic [PW-1:0] tprio  [NUM_TASKS];
  logic [31:0]   dcount [NUM_TASKS];
  logic [NUM_TASKS-1:0] delayed, evwait, queued;
  logic [7:0]    sleft  [NUM_TASKS];
  logic [TW-1:0] cur;
  logic [7:0]    lockc;
  logic [TW-1:0] walk;
  logic [15:0]   mask;
  logic          sw;
  state_t        state, state_next;

  logic [TW-1:0] t_sel;
  logic [PW-1:0] best;
  logic          do_sched;

  always_comb begin
    best = '0;
    for (int p = NUM_PRIORITIES - 1; p >= 0; p--) begin
      if (bitmap[p]) begin
        best = PW'(p);
      end
    end
  end

  assign t_sel = cmd_task[TW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    do_sched   = 1'b0;
    case (state)
      ST_IDLE: begin
        if (cmd_valid) begin
          state_next = (cmd_op == OP_TICK) ? ST_TICK_WALK : ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = ((cmd_op == OP_SCHEDULE) ||
                      (cmd_op == OP_UNLOCK && lockc == 8'd1)) ? ST_SCHED : ST_DONE;
      end
      ST_TICK_WALK: begin
        if (walk == TW'(NUM_TASKS - 1)) begin
          state_next = ST_SLICE;
        end
      end
      ST_SLICE: state_next = ST_SCHED;
      ST_SCHED: begin
        do_sched   = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!res_full) begin
          cmd_take   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign res_valid      = (state == ST_DONE) && !res_full;
  assign switch_request = sw;
  assign next_task      = 4'(cur);
  assign any_ready      = |bitmap;
  assign timed_out_mask = mask;
  assign lock_level     = lockc;

  always_ff @(posedge clk) begin
    logic [PW-1:0] p;
    logic [TW-1:0] nx, pv, h;
    logic [31:0]   dc;
    if (rst) begin
      bitmap  <= '0;
      delayed <= '0;
      evwait  <= '0;
      queued  <= '0;
      cur     <= '0;
      lockc   <= '0;
      walk    <= '0;
      mask    <= '0;
      sw      <= 1'b0;
      for (int i = 0; i < NUM_PRIORITIES; i++) begin
        qcount[i] <= '0;
        qhead[i]  <= '0;
        qtail[i]  <= '0;
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        sleft[i]  <= 8'(SLICE_INIT);
        dcount[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          walk <= '0;
          mask <= '0;
          sw   <= 1'b0;
        end
        ST_EXEC: begin
          case (cmd_op)
            OP_READY: begin
              if (cmd_task_ok && !queued[t_sel]) begin
                p = cmd_prio[PW-1:0];
                tprio[t_sel] <= p;
                if (qcount[p] == '0) begin
                  qtail[p] <= t_sel;
                end else begin
                  lnext[t_sel]    <= qhead[p];
                  lprev[qhead[p]] <= t_sel;
                end
                qhead[p]      <= t_sel;
                qcount[p]     <= qcount[p] + 1'b1;
                queued[t_sel] <= 1'b1;
                bitmap[p]     <= 1'b1;
              end
            end
            OP_UNREADY: begin
              if (cmd_task_ok && queued[t_sel]) begin
                p  = tprio[t_sel];
                nx = lnext[t_sel];
                pv = lprev[t_sel];
                if (qhead[p] == t_sel) begin
                  qhead[p] <= nx;
                end else begin
                  lnext[pv] <= nx;
                end
                if (qtail[p] == t_sel) begin
                  qtail[p] <= pv;
                end else begin
                  lprev[nx] <= pv;
                end
                qcount[p]     <= qcount[p] - 1'b1;
                queued[t_sel] <= 1'b0;
                if (qcount[p] == CW'(1)) begin
                  bitmap[p] <= 1'b0;
                end
              end
            end
            OP_DELAY: begin
              if (cmd_task_ok) begin
                dcount[t_sel]  <= cmd_ticks;
                delayed[t_sel] <= 1'b1;
                evwait[t_sel]  <= cmd_event;
              end
            end
            OP_WAKE: begin
              if (cmd_task_ok) begin
                delayed[t_sel] <= 1'b0;
                evwait[t_sel]  <= 1'b0;
              end
            end
            OP_LOCK: begin
              if (lockc != 8'(LOCK_MAX)) begin
                lockc <= lockc + 8'd1;
              end
            end
            OP_UNLOCK: begin
              if (lockc != 8'd0) begin
                lockc <= lockc - 8'd1;
              end
            end
            default: ;
          endcase
        end
        ST_TICK_WALK: begin
          walk <= walk + 1'b1;
          if (delayed[walk]) begin
            dc = dcount[walk] - 32'd1;
            dcount[walk] <= dc;
            if (dc == 32'd0) begin
              if (evwait[walk] && {{(32-TW){1'b0}}, walk} < 32'd16) begin
                mask[4'(walk)] <= 1'b1;
              end
              delayed[walk] <= 1'b0;
              evwait[walk]  <= 1'b0;
              if (!queued[walk]) begin
                p = tprio[walk];
                if (qcount[p] == '0) begin
                  qtail[p] <= walk;
                end else begin
                  lnext[walk]     <= qhead[p];
                  lprev[qhead[p]] <= walk;
                end
                qhead[p]     <= walk;
                qcount[p]    <= qcount[p] + 1'b1;
                queued[walk] <= 1'b1;
                bitmap[p]    <= 1'b1;
              end
            end
          end
        end
        ST_SLICE: begin
          if (sleft[cur] <= 8'd1) begin
            if (queued[cur]) begin
              p = tprio[cur];
              if (qcount[p] >= CW'(2)) begin
                h = qhead[p];
                qhead[p]        <= lnext[h];
                lnext[qtail[p]] <= h;
                lprev[h]        <= qtail[p];
                qtail[p]        <= h;
              end
            end
            sleft[cur] <= (slice_length == 8'd0) ? 8'd1 : slice_length;
          end else begin
            sleft[cur] <= sleft[cur] - 8'd1;
          end
        end
        ST_SCHED: begin
          if (do_sched && lockc == 8'd0 && |bitmap && qhead[best] != cur) begin
            cur <= qhead[best];
            sw  <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/pts_out_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_out_fifo
// Two-entry result queue between the executor and the pop side.
// ----------------------------------------------------------------------------
module pts_out_fifo (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        wr,
  output logic             wr_full,
  input  wire logic [30:0] wr_data,
  output logic             empty,
  input  wire logic        pop,
  output logic [30:0]      rd_data
);

  logic [30:0] mem [2];
  logic        wp, rp;
  logic [1:0]  fill;
  logic        rd;

  assign wr_full = fill[1];
  assign empty   = (fill == 2'd0);
  assign rd      = pop && !empty;
  assign rd_data = mem[rp];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wp] <= wr_data;
    end
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (wr) begin
        wp <= !wp;
      end
      if (rd) begin
        rp <= !rp;
      end
      fill <= fill + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/priority_task_scheduler.sv
`default_nettype none
// Flow: most operations pass EXEC and DONE; schedule and an unlock that
//   reaches zero also pass SCHED; a tick walks the delay counters one task
//   per cycle, then passes SLICE, SCHED and DONE, which waits while the
//   result queue is full. Commands are executed one at a time.
// Reset: synchronous rst empties both queues, clears all queues and marks,
//   loads slice_length with 10.
// ----------------------------------------------------------------------------
// priority_task_scheduler
// Bitmap priority scheduler with round robin inside each priority.
// ----------------------------------------------------------------------------
module priority_task_scheduler
  import pts_pkg::*;
#(
  parameter int NUM_PRIORITIES = 32,
  parameter int NUM_TASKS      = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        push,
  output logic             full,
  input  wire logic [2:0]  operation,
  input  wire logic [3:0]  task_id,
  input  wire logic [4:0]  priority_req,
  input  wire logic [31:0] delay_ticks,
  input  wire logic        waits_on_event,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  output logic             empty,
  input  wire logic        pop,
  output logic             switch_request,
  output logic [3:0]       next_task,
  output logic             any_ready,
  output logic [15:0]      timed_out_mask,
  output logic [7:0]       lock_level
);

  logic [7:0]  slice_length;
  logic        cmd_valid, cmd_take, cmd_task_ok, cmd_event;
  op_t         cmd_op;
  logic [3:0]  cmd_task;
  logic [4:0]  cmd_prio;
  logic [31:0] cmd_ticks;
  logic        res_valid, res_full, r_sw, r_any;
  logic [3:0]  r_next;
  logic [15:0] r_mask;
  logic [7:0]  r_lock;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_length <= 8'(SLICE_INIT);
    end else if (cfg_valid) begin
      slice_length <= cfg_data;
    end
  end

  pts_front #(.NUM_TASKS(NUM_TASKS), .NUM_PRIORITIES(NUM_PRIORITIES)) u_front (
    .clk, .rst, .push, .full, .operation, .task_id, .priority_req,
    .delay_ticks, .waits_on_event, .cmd_valid, .cmd_take, .cmd_op,
    .cmd_task_ok, .cmd_task, .cmd_prio, .cmd_ticks, .cmd_event
  );

  pts_back #(.NUM_TASKS(NUM_TASKS), .NUM_PRIORITIES(NUM_PRIORITIES)) u_back (
    .clk, .rst, .slice_length, .cmd_valid, .cmd_take, .cmd_op, .cmd_task_ok,
    .cmd_task, .cmd_prio, .cmd_ticks, .cmd_event, .res_valid, .res_full,
    .switch_request(r_sw), .next_task(r_next), .any_ready(r_any),
    .timed_out_mask(r_mask), .lock_level(r_lock)
  );

  pts_out_fifo u_out (
    .clk, .rst, .wr(res_valid), .wr_full(res_full),
    .wr_data({r_sw, r_next, r_any, r_mask, r_lock}),
    .empty, .pop,
    .rd_data({switch_request, next_task, any_ready, timed_out_mask, lock_level})
  );

endmodule
`default_nettype wire

>>> rtl/core/pts_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pts_checker
// Port-level properties of the scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module pts_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        full,
  input wire logic        empty,
  input wire logic        pop,
  input wire logic        switch_request,
  input wire logic [3:0]  next_task,
  input wire logic        any_ready,
  input wire logic [7:0]  lock_level
);

  a_sw_needs_ready: assert property (@(posedge clk) disable iff (rst)
    (!empty && switch_request) |-> any_ready)
    else $error("switch without ready task");

  a_sw_unlocked: assert property (@(posedge clk) disable iff (rst)
    (!empty && switch_request) |-> (lock_level == 8'd0))
    else $error("switch while locked");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(rst) |-> (empty && !full))
    else $error("queues not empty after reset");

  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> $stable(next_task))
    else $error("result changed while waiting");

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
  .clk, .rst, .full, .empty, .pop, .switch_request, .next_task,
  .any_ready, .lock_level
);
`default_nettype wire

>>> tb/priority_task_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_task_scheduler_tb
// Queue-style stimulus against a cycle-free scheduler predictor.
// A directed table covers reset state, delays of zero and of all ones and the
// event timeout; lock saturation and random bursts with several slice lengths
// follow. Beats are checked field by field against predictor or typed row.
// ----------------------------------------------------------------------------
module priority_task_scheduler_tb;
  import pts_pkg::*;

  localparam int NPRIO = 32;
  localparam int NTASK = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct packed {
    logic        sw;
    logic [3:0]  nxt;
    logic        any;
    logic [15:0] mask;
    logic [7:0]  lvl;
  } outcome_t;

  typedef struct {
    op_t         op;
    logic [3:0]  tid;
    logic [4:0]  prio;
    logic [31:0] dly;
    logic        ev;
    bit          typed;
    outcome_t    want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic [2:0]  operation = '0;
  logic [3:0]  task_id = '0;
  logic [4:0]  priority_req = '0;
  logic [31:0] delay_ticks = '0;
  logic        waits_on_event = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [7:0]  cfg_data = '0;
  logic        pop = 1'b0;
  logic        full, cfg_ready, empty;
  logic        switch_request, any_ready;
  logic [3:0]  next_task;
  logic [15:0] timed_out_mask;
  logic [7:0]  lock_level;

  priority_task_scheduler dut (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .operation(operation), .task_id(task_id), .priority_req(priority_req),
    .delay_ticks(delay_ticks), .waits_on_event(waits_on_event),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .empty(empty), .pop(pop), .switch_request(switch_request),
    .next_task(next_task), .any_ready(any_ready),
    .timed_out_mask(timed_out_mask), .lock_level(lock_level)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Scheduler predictor state
  logic [7:0]  slice_len;
  logic [31:0] rdy_map;
  logic [3:0]  q_head [NPRIO];
  logic [3:0]  q_tail [NPRIO];
  logic [4:0]  q_cnt  [NPRIO];
  logic [3:0]  nxt_of [NTASK];
  logic [3:0]  prv_of [NTASK];
  logic [4:0]  prio_of [NTASK];
  logic [31:0] dly_cnt [NTASK];
  logic        is_delayed [NTASK];
  logic        is_waiting [NTASK];
  logic [7:0]  slice_rem [NTASK];
  logic        in_queue [NTASK];
  logic [3:0]  cur_task;
  logic [7:0]  lock_cnt;

  outcome_t    result_q [$];
  int          fail_count = 0;
  int          cycle_count = 0;
  bit          long_hold = 1'b0;

  function automatic void sched_clear();
    slice_len = 8'(SLICE_INIT);
    rdy_map = '0;
    for (int p = 0; p < NPRIO; p++) begin
      q_head[p] = '0; q_tail[p] = '0; q_cnt[p] = '0;
    end
    for (int t = 0; t < NTASK; t++) begin
      nxt_of[t] = '0; prv_of[t] = '0; prio_of[t] = '0; dly_cnt[t] = '0;
      is_delayed[t] = 1'b0; is_waiting[t] = 1'b0; in_queue[t] = 1'b0;
      slice_rem[t] = 8'(SLICE_INIT);
    end
    cur_task = '0;
    lock_cnt = '0;
  endfunction

  function automatic void insert_head(int t);
    int p;
    p = prio_of[t];
    if (q_cnt[p] == 0) begin
      q_tail[p] = 4'(t);
    end else begin
      nxt_of[t] = q_head[p];
      prv_of[q_head[p]] = 4'(t);
    end
    q_head[p] = 4'(t);
    q_cnt[p]++;
    in_queue[t] = 1'b1;
    rdy_map[p] = 1'b1;
  endfunction

  function automatic void unlink(int t);
    int p, nx, pv;
    p = prio_of[t];
    nx = nxt_of[t];
    pv = prv_of[t];
    if (q_head[p] == t) q_head[p] = 4'(nx);
    else nxt_of[pv] = 4'(nx);
    if (q_tail[p] == t) q_tail[p] = 4'(pv);
    else prv_of[nx] = 4'(pv);
    q_cnt[p]--;
    in_queue[t] = 1'b0;
    if (q_cnt[p] == 0) rdy_map[p] = 1'b0;
  endfunction

  function automatic void rotate_queue(int p);
    int h;
    if (q_cnt[p] < 2) return;
    h = q_head[p];
    q_head[p] = nxt_of[h];
    nxt_of[q_tail[p]] = 4'(h);
    prv_of[h] = q_tail[p];
    q_tail[p] = 4'(h);
  endfunction

  function automatic logic pick_next();
    int p;
    if (lock_cnt != 0 || rdy_map == 0) return 1'b0;
    p = 0;
    while (!rdy_map[p]) p++;
    if (q_head[p] == cur_task) return 1'b0;
    cur_task = q_head[p];
    return 1'b1;
  endfunction

  function automatic outcome_t sched_apply(op_t op, logic [3:0] tid, logic [4:0] prio,
                                           logic [31:0] dly, logic ev);
    outcome_t o;
    int t;
    o = '0;
    t = tid;
    case (op)
      OP_READY: begin
        if (!in_queue[t]) begin
          prio_of[t] = prio;
          insert_head(t);
        end
      end
      OP_UNREADY: if (in_queue[t]) unlink(t);
      OP_DELAY: begin
        dly_cnt[t] = (dly == 0) ? 32'd1 : dly;
        is_delayed[t] = 1'b1;
        is_waiting[t] = ev;
      end
      OP_WAKE: begin
        is_delayed[t] = 1'b0;
        is_waiting[t] = 1'b0;
      end
      OP_TICK: begin
        for (int k = 0; k < NTASK; k++) begin
          if (is_delayed[k]) begin
            dly_cnt[k]--;
            if (dly_cnt[k] == 0) begin
              if (is_waiting[k]) o.mask[k] = 1'b1;
              is_delayed[k] = 1'b0;
              is_waiting[k] = 1'b0;
              if (!in_queue[k]) insert_head(k);
            end
          end
        end
        if (slice_rem[cur_task] <= 1) begin
          if (in_queue[cur_task]) rotate_queue(prio_of[cur_task]);
          slice_rem[cur_task] = (slice_len == 0) ? 8'd1 : slice_len;
        end else begin
          slice_rem[cur_task]--;
        end
        o.sw = pick_next();
      end
      OP_LOCK: if (lock_cnt < LOCK_MAX) lock_cnt++;
      OP_UNLOCK: begin
        if (lock_cnt > 0) begin
          lock_cnt--;
          if (lock_cnt == 0) o.sw = pick_next();
        end
      end
      default: o.sw = pick_next();
    endcase
    o.nxt = cur_task;
    o.any = (rdy_map != 0);
    o.lvl = lock_cnt;
    return o;
  endfunction

  task automatic report(string field, longint got, longint want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  // Offer one beat and hold it until accepted; returns at the accepting edge.
  task automatic offer(op_t op, logic [3:0] tid, logic [4:0] prio, logic [31:0] dly,
                       logic ev, bit typed = 0, outcome_t want = '0);
    outcome_t o;
    push <= 1'b1;
    operation <= op;
    task_id <= tid;
    priority_req <= prio;
    delay_ticks <= dly;
    waits_on_event <= ev;
    do @(posedge clk); while (full);
    o = sched_apply(op, tid, prio, dly, ev);
    result_q.push_back(typed ? want : o);
  endtask

  task automatic idle(int n);
    push <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    push <= 1'b0;
    while (result_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_slice(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    slice_len = v;
  endtask

  function automatic op_t rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 22) return OP_TICK;
    if (r < 42) return OP_READY;
    if (r < 54) return OP_UNREADY;
    if (r < 68) return OP_DELAY;
    if (r < 74) return OP_WAKE;
    if (r < 82) return OP_LOCK;
    if (r < 92) return OP_UNLOCK;
    return OP_SCHEDULE;
  endfunction

  task automatic random_phase(int n, bit with_hold);
    int burst;
    logic [31:0] dly;
    logic [4:0] prio;
    burst = 0;
    for (int i = 0; i < n; i++) begin
      if (burst == 0) begin
        if ($urandom_range(0, 3) != 0) idle($urandom_range(1, 8));
        burst = $urandom_range(1, 24);
      end
      burst--;
      if (with_hold && i == n / 2) long_hold = 1'b1;
      case ($urandom_range(0, 9))
        0: dly = $urandom();
        1: dly = 32'hFFFF_FFFF;
        default: dly = $urandom_range(0, 12);
      endcase
      prio = $urandom_range(0, 1) ? 5'($urandom_range(0, 3)) : 5'($urandom());
      offer(rand_op(), 4'($urandom()), prio, dly, 1'($urandom()));
    end
  endtask

  // Result side: pop follows a randomly chosen stall pattern, with one long hold
  initial begin
    int mode;
    mode = 0;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (long_hold) begin
        pop <= 1'b0;
        repeat (400) @(posedge clk);
        long_hold = 1'b0;
      end
      if (cycle_count % 256 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: pop <= 1'b1;
        1: pop <= 1'($urandom());
        2: pop <= ($urandom_range(0, 3) == 0);
        default: pop <= (cycle_count % 7 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    outcome_t w;
    if (!rst && pop && !empty) begin
      if (result_q.size() == 0) begin
        report("unexpected beat", next_task, 0);
      end else begin
        w = result_q.pop_front();
        if (switch_request !== w.sw) report("switch_request", switch_request, w.sw);
        if (next_task !== w.nxt) report("next_task", next_task, w.nxt);
        if (any_ready !== w.any) report("any_ready", any_ready, w.any);
        if (timed_out_mask !== w.mask) report("timed_out_mask", timed_out_mask, w.mask);
        if (lock_level !== w.lvl) report("lock_level", lock_level, w.lvl);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    stim_row_t rows [$];
    logic [7:0] slices [4];
    sched_clear();
    // sw, next, any, mask, level
    rows.push_back('{OP_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{OP_LOCK, 4'd0, 5'd0, 32'd0, 1'b0, 1, '{0, 0, 0, 0, 1}});
    rows.push_back('{OP_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{OP_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0, 1, '{0, 0, 0, 0, 0}});
    rows.push_back('{OP_READY, 4'd15, 5'd31, 32'd0, 1'b0, 1, '{0, 0, 1, 0, 0}});
    rows.push_back('{OP_READY, 4'd15, 5'd0, 32'd0, 1'b0, 1, '{0, 0, 1, 0, 0}});
    rows.push_back('{OP_READY, 4'd3, 5'd31, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_UNREADY, 4'd7, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_DELAY, 4'd5, 5'd0, 32'd0, 1'b1, 0, '0});
    rows.push_back('{OP_DELAY, 4'd9, 5'd0, 32'hFFFF_FFFF, 1'b1, 0, '0});
    rows.push_back('{OP_DELAY, 4'd0, 5'd0, 32'd1, 1'b0, 0, '0});
    rows.push_back('{OP_TICK, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_READY, 4'd8, 5'd2, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_DELAY, 4'd8, 5'd0, 32'd2, 1'b1, 0, '0});
    rows.push_back('{OP_WAKE, 4'd9, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_LOCK, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_TICK, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_TICK, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_UNLOCK, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_UNREADY, 4'd15, 5'd0, 32'd0, 1'b0, 0, '0});
    rows.push_back('{OP_SCHEDULE, 4'd0, 5'd0, 32'd0, 1'b0, 0, '0});

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i])
      offer(rows[i].op, rows[i].tid, rows[i].prio, rows[i].dly, rows[i].ev,
            rows[i].typed, rows[i].want);
    // lock saturation and full unwind
    repeat (257) offer(OP_LOCK, '0, '0, '0, 1'b0);
    repeat (257) offer(OP_UNLOCK, '0, '0, '0, 1'b0);
    drain();

    slices = '{8'd1, 8'd255, 8'd3, 8'($urandom_range(1, 255))};
    foreach (slices[k]) begin
      write_slice(slices[k]);
      random_phase(300, k == 0);
      drain();
    end

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/pts_pkg.sv
rtl/core/pts_front.sv
rtl/core/pts_back.sv
rtl/core/pts_out_fifo.sv
rtl/core/priority_task_scheduler.sv
rtl/core/pts_checker.sv
tb/priority_task_scheduler_tb.sv
